// ===== src/rgb_led_effect_controller_defines.svh =====
// assertion macros shared by the led effect controller checkers
`ifndef RGB_LED_EFFECT_CONTROLLER_DEFINES_SVH
`define RGB_LED_EFFECT_CONTROLLER_DEFINES_SVH

// same-cycle implication, reported with the enclosing scope
`define RLEC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define RLEC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== src/rlec_pkg.sv =====
// shared types and constants of the led effect controller
package rlec_pkg;

   localparam int CHAN_W     = 8;
   localparam int RGB_W      = 3 * CHAN_W;
   localparam int MODE_W     = 3;
   localparam int INTERVAL_W = 16;
   localparam int ELAPSED_W  = 9;
   localparam int TOGGLE_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // command codes
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SATURATION = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd3;

   // register reset values
   localparam logic [CHAN_W-1:0] STEP_RST       = 8'd3;
   localparam logic [CHAN_W-1:0] PERIOD_RST     = 8'd30;
   localparam logic [CHAN_W-1:0] SATURATION_RST = 8'd255;
   localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd100;

   // hsv conversion constants
   localparam int                HUE_SECTOR = 43;
   localparam int                REM_SCALE  = 6;
   localparam int                NUM_SECTOR = 6;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
   localparam logic [RGB_W-1:0]  RGB_BLACK  = 24'h000000;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 9'd511;

   typedef struct packed {
      logic capture;
      logic exec;
      logic hsv_a;
      logic hsv_b;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic need_hsv;
   } sts_type;

endpackage

// ===== src/rlec_ifs.sv =====
// request and response channel interfaces of the led effect controller
interface rlec_req_if;
   logic                                valid;
   logic                                ready;
   logic [rlec_pkg::MODE_W-1:0]         mode;
   logic [rlec_pkg::CHAN_W-1:0]         red;
   logic [rlec_pkg::CHAN_W-1:0]         green;
   logic [rlec_pkg::CHAN_W-1:0]         blue;
   logic [rlec_pkg::CHAN_W-1:0]         flash_count;
   logic [rlec_pkg::INTERVAL_W-1:0]     flash_interval;
   logic                                suspend;

   modport source (output valid, mode, red, green, blue, flash_count, flash_interval,
                   suspend, input ready);
   modport sink (input valid, mode, red, green, blue, flash_count, flash_interval,
                 suspend, output ready);
endinterface

interface rlec_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rlec_pkg::CHAN_W-1:0] led_red;
   logic [rlec_pkg::CHAN_W-1:0] led_green;
   logic [rlec_pkg::CHAN_W-1:0] led_blue;

   modport source (output valid, led_red, led_green, led_blue, input ready);
   modport sink (input valid, led_red, led_green, led_blue, output ready);
endinterface

// ===== src/rlec_datapath.sv =====
// effect state, registers, hsv conversion and output register
module rlec_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rlec_pkg::cmd_type                   cmd,
   output rlec_pkg::sts_type                   sts,
   input  logic [rlec_pkg::MODE_W-1:0]         mode,
   input  logic [rlec_pkg::CHAN_W-1:0]         red,
   input  logic [rlec_pkg::CHAN_W-1:0]         green,
   input  logic [rlec_pkg::CHAN_W-1:0]         blue,
   input  logic [rlec_pkg::CHAN_W-1:0]         flash_count,
   input  logic [rlec_pkg::INTERVAL_W-1:0]     flash_interval,
   input  logic                                suspend,
   input  logic                                csr_we,
   input  logic [rlec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rlec_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [rlec_pkg::CHAN_W-1:0]         led_red,
   output logic [rlec_pkg::CHAN_W-1:0]         led_green,
   output logic [rlec_pkg::CHAN_W-1:0]         led_blue
);

   // captured transaction
   logic [rlec_pkg::MODE_W-1:0]     mode_ff;
   logic [rlec_pkg::RGB_W-1:0]      colour_ff;
   logic [rlec_pkg::CHAN_W-1:0]     count_ff;
   logic [rlec_pkg::INTERVAL_W-1:0] interval_ff;
   logic                            suspend_ff;

   // configuration
   logic [rlec_pkg::CHAN_W-1:0] step_ff, period_ff, sat_ff, bright_ff;

   // effect state
   logic                            suspended_ff, suspended_in;
   logic                            flashing_ff, flashing_in;
   logic                            rainbow_ff, rainbow_in;
   logic                            lit_ff, lit_in;
   logic [rlec_pkg::CHAN_W-1:0]     hue_ff, hue_in;
   logic [rlec_pkg::ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [rlec_pkg::RGB_W-1:0]      flash_colour_ff, flash_colour_in;
   logic [rlec_pkg::TOGGLE_W-1:0]   toggles_ff, toggles_in;
   logic [rlec_pkg::INTERVAL_W-1:0] wait_ff, wait_in;
   logic [rlec_pkg::INTERVAL_W-1:0] flash_interval_ff, flash_interval_in;

   logic [rlec_pkg::RGB_W-1:0]      direct_rgb;
   logic [rlec_pkg::INTERVAL_W-1:0] wait_dec;
   logic [rlec_pkg::ELAPSED_W-1:0]  elapsed_inc;

   // hsv pipeline
   logic [2:0]                  region_ff, region_in;
   logic [rlec_pkg::CHAN_W-1:0] p_arg_ff, q_arg_ff, t_arg_ff;
   logic [rlec_pkg::CHAN_W-1:0] p_arg_in, q_arg_in, t_arg_in;
   logic [rlec_pkg::CHAN_W-1:0] base, rem;
   logic [2*rlec_pkg::CHAN_W-1:0] sr_prod, st_prod, p_prod, q_prod, t_prod;
   logic [rlec_pkg::CHAN_W-1:0] p_val, q_val, t_val, v_val;
   logic [rlec_pkg::RGB_W-1:0]  hsv_rgb;

   logic [rlec_pkg::RGB_W-1:0]  res_ff;
   logic [rlec_pkg::RGB_W-1:0]  out_ff;

   // command evaluation
   always_comb begin
      suspended_in      = suspended_ff;
      flashing_in       = flashing_ff;
      rainbow_in        = rainbow_ff;
      lit_in            = lit_ff;
      hue_in            = hue_ff;
      elapsed_in        = elapsed_ff;
      flash_colour_in   = flash_colour_ff;
      toggles_in        = toggles_ff;
      wait_in           = wait_ff;
      flash_interval_in = flash_interval_ff;
      direct_rgb        = rlec_pkg::RGB_BLACK;
      sts               = '0;
      wait_dec    = (wait_ff != '0) ? wait_ff - 16'd1 : wait_ff;
      elapsed_inc = (elapsed_ff != rlec_pkg::ELAPSED_MAX) ? elapsed_ff + 9'd1 : elapsed_ff;

      unique case (mode_ff)
         rlec_pkg::MODE_SUSPEND: begin
            suspended_in = suspend_ff;
            if (suspend_ff) begin
               flashing_in = 1'b0;
               rainbow_in  = 1'b0;
            end
         end
         rlec_pkg::MODE_SOLID: begin
            if (!suspended_ff) begin
               flashing_in    = 1'b0;
               rainbow_in     = 1'b0;
               direct_rgb     = colour_ff;
               sts.has_result = 1'b1;
            end
         end
         rlec_pkg::MODE_FLASH: begin
            if (!suspended_ff) begin
               flashing_in       = 1'b1;
               rainbow_in        = 1'b0;
               flash_colour_in   = colour_ff;
               toggles_in        = {count_ff, 1'b0};
               flash_interval_in = interval_ff;
               wait_in           = '0;
               lit_in            = 1'b0;
            end
         end
         rlec_pkg::MODE_RAINBOW: begin
            if (!suspended_ff) begin
               flashing_in = 1'b0;
               rainbow_in  = 1'b1;
               elapsed_in  = '0;
            end
         end
         rlec_pkg::MODE_TICK: begin
            if (!suspended_ff) begin
               if (flashing_ff) begin
                  wait_in = wait_dec;
                  if (wait_dec == '0) begin
                     sts.has_result = 1'b1;
                     if (toggles_ff != '0) begin
                        lit_in     = !lit_ff;
                        direct_rgb = lit_ff ? rlec_pkg::RGB_BLACK : flash_colour_ff;
                        wait_in    = flash_interval_ff;
                        toggles_in = toggles_ff - 9'd1;
                     end else begin
                        flashing_in = 1'b0;
                     end
                  end
               end else if (rainbow_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > {1'b0, period_ff}) begin
                     elapsed_in     = '0;
                     hue_in         = hue_ff + step_ff;
                     sts.has_result = 1'b1;
                     sts.need_hsv   = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // hsv first step: sector, remainder and the saturation products
   always_comb begin
      region_in = '0;
      base      = '0;
      for (int k = 1; k < rlec_pkg::NUM_SECTOR; k++) begin
         if (hue_ff >= 8'(k * rlec_pkg::HUE_SECTOR)) begin
            region_in = 3'(k);
            base      = 8'(k * rlec_pkg::HUE_SECTOR);
         end
      end
      rem      = 8'((hue_ff - base) * 8'(rlec_pkg::REM_SCALE));
      sr_prod  = sat_ff * rem;
      st_prod  = sat_ff * (rlec_pkg::CHAN_MAX - rem);
      p_arg_in = rlec_pkg::CHAN_MAX - sat_ff;
      q_arg_in = rlec_pkg::CHAN_MAX - sr_prod[15:8];
      t_arg_in = rlec_pkg::CHAN_MAX - st_prod[15:8];
   end

   // hsv second step: brightness products and channel mapping
   always_comb begin
      v_val  = bright_ff;
      p_prod = v_val * p_arg_ff;
      q_prod = v_val * q_arg_ff;
      t_prod = v_val * t_arg_ff;
      p_val  = p_prod[15:8];
      q_val  = q_prod[15:8];
      t_val  = t_prod[15:8];
      case (region_ff)
         3'd0:    hsv_rgb = {v_val, t_val, p_val};
         3'd1:    hsv_rgb = {q_val, v_val, p_val};
         3'd2:    hsv_rgb = {p_val, v_val, t_val};
         3'd3:    hsv_rgb = {p_val, q_val, v_val};
         3'd4:    hsv_rgb = {t_val, p_val, v_val};
         default: hsv_rgb = {v_val, p_val, q_val};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff           <= rlec_pkg::STEP_RST;
         period_ff         <= rlec_pkg::PERIOD_RST;
         sat_ff            <= rlec_pkg::SATURATION_RST;
         bright_ff         <= rlec_pkg::BRIGHTNESS_RST;
         suspended_ff      <= 1'b0;
         flashing_ff       <= 1'b0;
         rainbow_ff        <= 1'b0;
         lit_ff            <= 1'b0;
         hue_ff            <= '0;
         elapsed_ff        <= '0;
         flash_colour_ff   <= rlec_pkg::RGB_BLACK;
         toggles_ff        <= '0;
         wait_ff           <= '0;
         flash_interval_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               rlec_pkg::CSR_STEP:       step_ff   <= csr_wdata;
               rlec_pkg::CSR_PERIOD:     period_ff <= csr_wdata;
               rlec_pkg::CSR_SATURATION: sat_ff    <= csr_wdata;
               rlec_pkg::CSR_BRIGHTNESS: bright_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.exec) begin
            suspended_ff      <= suspended_in;
            flashing_ff       <= flashing_in;
            rainbow_ff        <= rainbow_in;
            lit_ff            <= lit_in;
            hue_ff            <= hue_in;
            elapsed_ff        <= elapsed_in;
            flash_colour_ff   <= flash_colour_in;
            toggles_ff        <= toggles_in;
            wait_ff           <= wait_in;
            flash_interval_ff <= flash_interval_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= mode;
         colour_ff   <= {red, green, blue};
         count_ff    <= flash_count;
         interval_ff <= flash_interval;
         suspend_ff  <= suspend;
      end
      if (cmd.hsv_a) begin
         region_ff <= region_in;
         p_arg_ff  <= p_arg_in;
         q_arg_ff  <= q_arg_in;
         t_arg_ff  <= t_arg_in;
      end
      if (cmd.exec) begin
         res_ff <= direct_rgb;
      end else if (cmd.hsv_b) begin
         res_ff <= hsv_rgb;
      end
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   assign led_red   = out_ff[23:16];
   assign led_green = out_ff[15:8];
   assign led_blue  = out_ff[7:0];

endmodule

// ===== src/rlec_ctrl.sv =====
// sequencing state machine of the led effect controller
module rlec_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rlec_pkg::sts_type sts,
   output rlec_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HSV_A,
      ST_HSV_B,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      slot_free    = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_hsv) begin
               state_in = ST_HSV_A;
            end else if (sts.has_result) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HSV_A: begin
            cmd.hsv_a = 1'b1;
            state_in  = ST_HSV_B;
         end
         ST_HSV_B: begin
            cmd.hsv_b = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/rgb_led_effect_controller.sv =====
// top level of the rgb led effect controller
//
//   channel   role    payload
//   req_bus   sink    mode, red, green, blue, flash_count, flash_interval, suspend
//   rsp_bus   source  led_red, led_green, led_blue
//   csr_*     write   csr_we, csr_index, csr_wdata (no read-back)
//
// a command that writes nothing passes through capture and evaluation only, a solid
// colour or flash step also through emit, and a rainbow update also through the two
// hsv multiply steps, in sequence, one transaction at a time under the control fsm.
// the output register holds a result until taken; a new transaction is accepted
// meanwhile and only waits in its emit step if the register is still full.
// reset is synchronous and restores the register defaults and an idle, unsuspended led.
module rgb_led_effect_controller (
   input  logic                                clock,
   input  logic                                reset,
   rlec_req_if.sink                            req_bus,
   rlec_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [rlec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rlec_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rlec_pkg::cmd_type cmd;
   rlec_pkg::sts_type sts;
   logic              req_ready;
   logic              rsp_valid;

   // sequencing: capture, evaluate, optional hsv steps, emit
   rlec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // effect state, configuration registers and colour math
   rlec_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .mode           (req_bus.mode),
      .red            (req_bus.red),
      .green          (req_bus.green),
      .blue           (req_bus.blue),
      .flash_count    (req_bus.flash_count),
      .flash_interval (req_bus.flash_interval),
      .suspend        (req_bus.suspend),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .led_red        (rsp_bus.led_red),
      .led_green      (rsp_bus.led_green),
      .led_blue       (rsp_bus.led_blue)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

// ===== src/rlec_checker.sv =====
// port-level checks of the led effect controller and their bind
`include "rgb_led_effect_controller_defines.svh"

module rlec_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [rlec_pkg::MODE_W-1:0]    req_mode,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rlec_pkg::CHAN_W-1:0]    rsp_led_red,
   input logic [rlec_pkg::CHAN_W-1:0]    rsp_led_green,
   input logic [rlec_pkg::CHAN_W-1:0]    rsp_led_blue
);

   logic [rlec_pkg::RGB_W-1:0] rsp_rgb;
   logic                       suspend_accept;

   assign rsp_rgb        = {rsp_led_red, rsp_led_green, rsp_led_blue};
   // suspend transaction taken while no result is offered
   assign suspend_accept = req_valid && req_ready && (req_mode == rlec_pkg::MODE_SUSPEND)
                           && !rsp_valid;

   // a pending result is not withdrawn
   `RLEC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a pending result keeps its colour
   `RLEC_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_rgb))

   // one transaction in flight: no accept in the cycle after one
   `RLEC_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // a suspend command never lights the output
   `RLEC_ASSERT_NXT(a_suspend_silent, clock, reset, suspend_accept, !rsp_valid ##1 !rsp_valid)

   // nothing is offered right after reset
   `RLEC_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind rgb_led_effect_controller rlec_checker u_rlec_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_mode      (req_bus.mode),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_led_red   (rsp_bus.led_red),
   .rsp_led_green (rsp_bus.led_green),
   .rsp_led_blue  (rsp_bus.led_blue)
);

// ===== verif/rlec_led_checker.sv =====
// led write predictor and checker for the rgb led effect controller testbench
module rlec_led_checker (
   input  logic                            clock,
   input  logic                            reset,
   rlec_req_if                             req_mon,
   rlec_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [rlec_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlec_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   typedef logic [rlec_pkg::RGB_W-1:0] rgb_type;

   // predicted led writes, oldest first
   rgb_type led_writes_due[$];

   // register copies
   logic [rlec_pkg::CHAN_W-1:0] step_r, period_r, sat_r, bright_r;

   // effect state
   logic                            is_suspended, flash_on, rainbow_run, lit;
   logic [rlec_pkg::CHAN_W-1:0]     hue;
   logic [rlec_pkg::ELAPSED_W-1:0]  elapsed;
   rgb_type                         flash_colour;
   logic [rlec_pkg::TOGGLE_W-1:0]   toggles_left;
   logic [rlec_pkg::INTERVAL_W-1:0] hold_ticks, flash_gap;

   // 8-bit integer hsv to rgb
   function automatic rgb_type hue_to_rgb(input logic [rlec_pkg::CHAN_W-1:0] h, s, v);
      int unsigned hi, si, vi, sector, frac, p, q, t;
      logic [rlec_pkg::CHAN_W-1:0] r, g, b;
      hi = 32'(h);
      si = 32'(s);
      vi = 32'(v);
      sector = hi / rlec_pkg::HUE_SECTOR;
      frac = (hi - sector * rlec_pkg::HUE_SECTOR) * rlec_pkg::REM_SCALE;
      p = (vi * (255 - si)) >> 8;
      q = (vi * (255 - ((si * frac) >> 8))) >> 8;
      t = (vi * (255 - ((si * (255 - frac)) >> 8))) >> 8;
      case (sector)
         0: begin r = v; g = t[7:0]; b = p[7:0]; end
         1: begin r = q[7:0]; g = v; b = p[7:0]; end
         2: begin r = p[7:0]; g = v; b = t[7:0]; end
         3: begin r = p[7:0]; g = q[7:0]; b = v; end
         4: begin r = t[7:0]; g = p[7:0]; b = v; end
         default: begin r = v; g = p[7:0]; b = q[7:0]; end
      endcase
      return {r, g, b};
   endfunction

   task automatic clear_state();
      step_r = rlec_pkg::STEP_RST;
      period_r = rlec_pkg::PERIOD_RST;
      sat_r = rlec_pkg::SATURATION_RST;
      bright_r = rlec_pkg::BRIGHTNESS_RST;
      is_suspended = 1'b0;
      flash_on = 1'b0;
      rainbow_run = 1'b0;
      lit = 1'b0;
      hue = '0;
      elapsed = '0;
      flash_colour = rlec_pkg::RGB_BLACK;
      toggles_left = '0;
      hold_ticks = '0;
      flash_gap = '0;
   endtask

   // advance the effect state by one command, report the led write it causes
   task automatic step_led(output bit wrote, output rgb_type led);
      rgb_type colour;
      colour = {req_mon.red, req_mon.green, req_mon.blue};
      wrote = 1'b0;
      led = rlec_pkg::RGB_BLACK;
      if (req_mon.mode == rlec_pkg::MODE_SUSPEND) begin
         is_suspended = req_mon.suspend;
         if (req_mon.suspend) begin
            flash_on = 1'b0;
            rainbow_run = 1'b0;
         end
      end else if (!is_suspended) begin
         case (req_mon.mode)
            rlec_pkg::MODE_SOLID: begin
               flash_on = 1'b0;
               rainbow_run = 1'b0;
               wrote = 1'b1;
               led = colour;
            end
            rlec_pkg::MODE_FLASH: begin
               flash_on = 1'b1;
               rainbow_run = 1'b0;
               flash_colour = colour;
               toggles_left = {req_mon.flash_count, 1'b0};
               flash_gap = req_mon.flash_interval;
               hold_ticks = '0;
               lit = 1'b0;
            end
            rlec_pkg::MODE_RAINBOW: begin
               flash_on = 1'b0;
               rainbow_run = 1'b1;
               elapsed = '0;
            end
            rlec_pkg::MODE_TICK: begin
               if (flash_on) begin
                  if (hold_ticks != 0) hold_ticks--;
                  if (hold_ticks == 0) begin
                     wrote = 1'b1;
                     if (toggles_left != 0) begin
                        lit = !lit;
                        led = lit ? flash_colour : rlec_pkg::RGB_BLACK;
                        hold_ticks = flash_gap;
                        toggles_left--;
                     end else begin
                        flash_on = 1'b0;
                     end
                  end
               end else if (rainbow_run) begin
                  if (elapsed != rlec_pkg::ELAPSED_MAX) elapsed++;
                  if (elapsed > {1'b0, period_r}) begin
                     elapsed = '0;
                     hue = hue + step_r;
                     wrote = 1'b1;
                     led = hue_to_rgb(hue, sat_r, bright_r);
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      rgb_type want, got, led;
      bit      wrote;
      if (reset) begin
         clear_state();
         led_writes_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.led_red, rsp_mon.led_green, rsp_mon.led_blue};
            if (led_writes_due.size() == 0) begin
               $error("unexpected led write %06h", got);
               fail_count++;
            end else begin
               want = led_writes_due.pop_front();
               if (got[23:16] !== want[23:16]) begin
                  $error("led_red expected %0d actual %0d", want[23:16], got[23:16]);
                  fail_count++;
               end
               if (got[15:8] !== want[15:8]) begin
                  $error("led_green expected %0d actual %0d", want[15:8], got[15:8]);
                  fail_count++;
               end
               if (got[7:0] !== want[7:0]) begin
                  $error("led_blue expected %0d actual %0d", want[7:0], got[7:0]);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               rlec_pkg::CSR_STEP:       step_r = csr_wdata;
               rlec_pkg::CSR_PERIOD:     period_r = csr_wdata;
               rlec_pkg::CSR_SATURATION: sat_r = csr_wdata;
               rlec_pkg::CSR_BRIGHTNESS: bright_r = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            step_led(wrote, led);
            if (wrote) led_writes_due.push_back(led);
         end
      end
      pending <= led_writes_due.size();
   end

endmodule

// ===== verif/tb_rgb_led_effect_controller.sv =====
// top of the rgb led effect controller testbench: stimulus, handshake pacing and verdict
module tb_rgb_led_effect_controller;

   // cycles with no transaction and no register write before giving up
   localparam int WATCHDOG_LIMIT = 4000;
   // drain time once nothing is expected
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS = 305;

   typedef struct packed {
      logic [rlec_pkg::MODE_W-1:0]     mode;
      logic [rlec_pkg::RGB_W-1:0]      colour;
      logic [rlec_pkg::CHAN_W-1:0]     count;
      logic [rlec_pkg::INTERVAL_W-1:0] gap;
      logic                            susp;
   } led_cmd_type;

   logic clock;
   logic reset;
   logic                            csr_we;
   logic [rlec_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rlec_pkg::CSR_DATA_W-1:0] csr_wdata;

   rlec_req_if req_bus();
   rlec_rsp_if rsp_bus();

   int led_pending;
   int led_errors;
   int items_sent;
   int idle_cycles;
   int cur_period;
   // no idling on either side while set
   bit calm;

   rgb_led_effect_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rlec_led_checker led_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (led_errors),
      .pending    (led_pending)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: stall with a probability of about 12 in a hundred unless calm
   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 12);
   end

   // watchdog: any transaction or register write restarts the count
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("rgb_led_effect_controller test failed");
            $finish;
         end
      end
   end

   function automatic led_cmd_type mk(input logic [rlec_pkg::MODE_W-1:0] m,
                                      input logic [rlec_pkg::RGB_W-1:0] rgb,
                                      input logic [rlec_pkg::CHAN_W-1:0] cnt,
                                      input logic [rlec_pkg::INTERVAL_W-1:0] gap,
                                      input logic sus);
      led_cmd_type c;
      c.mode = m;
      c.colour = rgb;
      c.count = cnt;
      c.gap = gap;
      c.susp = sus;
      return c;
   endfunction

   // given mode, every other field random
   function automatic led_cmd_type any_cmd(input logic [rlec_pkg::MODE_W-1:0] m);
      return mk(m, 24'($urandom), 8'($urandom_range(255)), 16'($urandom_range(65535)),
                1'($urandom_range(1)));
   endfunction

   // called at a clock edge; returns at the edge where the transaction is taken
   task automatic push_cmd(input led_cmd_type c);
      int gap_len;
      if (!calm && $urandom_range(99) < 12) begin
         gap_len = $urandom_range(4, 1);
         req_bus.valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= c.mode;
      req_bus.red <= c.colour[23:16];
      req_bus.green <= c.colour[15:8];
      req_bus.blue <= c.colour[7:0];
      req_bus.flash_count <= c.count;
      req_bus.flash_interval <= c.gap;
      req_bus.suspend <= c.susp;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_cmd(any_cmd(rlec_pkg::MODE_TICK));
   endtask

   // drop valid, wait for every predicted write, then let the pipeline drain
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (led_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called while the block is idle
   task automatic set_regs(input logic [7:0] st, pe, sa, br);
      csr_we <= 1'b1;
      csr_index <= rlec_pkg::CSR_STEP;
      csr_wdata <= st;
      @(posedge clock);
      csr_index <= rlec_pkg::CSR_PERIOD;
      csr_wdata <= pe;
      @(posedge clock);
      csr_index <= rlec_pkg::CSR_SATURATION;
      csr_wdata <= sa;
      @(posedge clock);
      csr_index <= rlec_pkg::CSR_BRIGHTNESS;
      csr_wdata <= br;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_period = int'(pe);
   endtask

   // one random scenario: mostly well-formed effect sequences, some noise
   task automatic random_scenario();
      int sel, cnt, gap, span, n;
      sel = $urandom_range(99);
      if (sel < 35) begin
         // flash burst followed by a random run of ticks, up to 60, that may run it out
         cnt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4);
         gap = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(3);
         span = cnt * 2 * (gap + 1) + 3;
         if (span > 60) span = 60;
         push_cmd(mk(rlec_pkg::MODE_FLASH, 24'($urandom), 8'(cnt), 16'(gap),
                     1'($urandom_range(1))));
         push_ticks($urandom_range(span, 1));
      end else if (sel < 60) begin
         // rainbow start then a run of ticks spanning a few updates
         span = 3 * (cur_period + 1);
         if (span > 120) span = 120;
         push_cmd(any_cmd(rlec_pkg::MODE_RAINBOW));
         push_ticks($urandom_range(span, 1));
      end else if (sel < 70) begin
         push_cmd(any_cmd(rlec_pkg::MODE_SOLID));
         push_ticks($urandom_range(3));
      end else if (sel < 80) begin
         // suspend, up to four random commands (ignored unless they are suspend commands), resume
         push_cmd(mk(rlec_pkg::MODE_SUSPEND, 24'($urandom), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), 1'b1));
         n = $urandom_range(4);
         repeat (n) push_cmd(any_cmd(3'($urandom_range(7))));
         push_cmd(mk(rlec_pkg::MODE_SUSPEND, 24'($urandom), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), 1'b0));
      end else begin
         push_cmd(any_cmd(3'($urandom_range(7))));
      end
   endtask

   task automatic run_phase(input int budget);
      int stop;
      stop = items_sent + budget;
      while (items_sent < stop) random_scenario();
   endtask

   initial begin
      // known values on every input before the first edge
      reset = 1'b1;
      calm = 1'b0;
      items_sent = 0;
      cur_period = int'(rlec_pkg::PERIOD_RST);
      csr_we = 1'b0;
      csr_index = rlec_pkg::CSR_STEP;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = rlec_pkg::MODE_TICK;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.flash_count = '0;
      req_bus.flash_interval = '0;
      req_bus.suspend = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fast rainbow with hue wrap so every tick updates
      set_regs(8'd255, 8'd0, 8'd255, 8'd255);
      push_cmd(mk(rlec_pkg::MODE_SOLID, 24'h000000, 8'd0, 16'd0, 1'b0));
      push_cmd(mk(rlec_pkg::MODE_SOLID, 24'hffffff, 8'hff, 16'hffff, 1'b1));
      // one on-off cycle at zero interval: on, off, then final black
      push_cmd(mk(rlec_pkg::MODE_FLASH, 24'ha55ac3, 8'd1, 16'd0, 1'b0));
      push_ticks(3);
      // zero count goes straight to black on the first tick
      push_cmd(mk(rlec_pkg::MODE_FLASH, 24'hff00ff, 8'd0, 16'hffff, 1'b0));
      push_ticks(1);
      // interval of two: toggle, hold, toggle
      push_cmd(mk(rlec_pkg::MODE_FLASH, 24'h123456, 8'd1, 16'd2, 1'b0));
      push_ticks(3);
      // rainbow start cancels the running flash
      push_cmd(mk(rlec_pkg::MODE_RAINBOW, 24'h000000, 8'd0, 16'd0, 1'b0));
      push_ticks(3);
      // suspended: tick and solid colour ignored, repeated suspend still applies
      push_cmd(mk(rlec_pkg::MODE_SUSPEND, 24'h000000, 8'd0, 16'd0, 1'b1));
      push_cmd(mk(rlec_pkg::MODE_TICK, 24'hffffff, 8'hff, 16'hffff, 1'b0));
      push_cmd(mk(rlec_pkg::MODE_SOLID, 24'hffffff, 8'd0, 16'd0, 1'b0));
      push_cmd(mk(rlec_pkg::MODE_SUSPEND, 24'h000000, 8'd0, 16'd0, 1'b1));
      push_cmd(mk(rlec_pkg::MODE_SUSPEND, 24'hffffff, 8'hff, 16'hffff, 1'b0));
      // suspend cancelled the rainbow, so this tick writes nothing
      push_cmd(mk(rlec_pkg::MODE_TICK, 24'h000000, 8'd0, 16'd0, 1'b0));
      // unused command codes
      push_cmd(any_cmd(3'd5));
      push_cmd(any_cmd(3'd6));
      push_cmd(any_cmd(3'd7));
      // largest count and interval: the first tick still lights at once
      push_cmd(mk(rlec_pkg::MODE_FLASH, 24'h80ff01, 8'hff, 16'hffff, 1'b0));
      push_ticks(1);
      push_cmd(mk(rlec_pkg::MODE_SOLID, 24'h010203, 8'd0, 16'd0, 1'b0));
      quiesce();

      // random phases, each under its own register setting
      set_regs(rlec_pkg::STEP_RST, rlec_pkg::PERIOD_RST, rlec_pkg::SATURATION_RST,
               rlec_pkg::BRIGHTNESS_RST);
      run_phase(PHASE_ITEMS);
      quiesce();
      // all-zero registers, with neither side idling
      set_regs(8'd0, 8'd0, 8'd0, 8'd0);
      calm = 1'b1;
      run_phase(PHASE_ITEMS);
      calm = 1'b0;
      quiesce();
      set_regs(8'd255, 8'd255, 8'd255, 8'd255);
      run_phase(PHASE_ITEMS);
      quiesce();
      set_regs(8'($urandom_range(255)), 8'($urandom_range(7)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
      run_phase(PHASE_ITEMS);
      quiesce();
      set_regs(8'd1, 8'd2, 8'd128, 8'd200);
      run_phase(PHASE_ITEMS);
      quiesce();
      set_regs(8'($urandom_range(255)), 8'($urandom_range(15)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
      run_phase(PHASE_ITEMS);
      quiesce();

      if (led_errors == 0) begin
         $display("rgb_led_effect_controller test passed");
      end else begin
         $display("rgb_led_effect_controller test failed");
      end
      $finish;
   end

endmodule
